### rtl/ipv4p_pkg.sv
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants of the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned VALUE_W   = 34;
  localparam int unsigned PROD_W    = 38;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned LEN_W     = 4;

  // Longest part in characters, prefix included.
  localparam logic [LEN_W-1:0] MAX_PART_CHARS = LEN_W'(10);
  localparam logic [LEN_W-1:0] LEN_SAT        = '1;

  localparam logic [CHAR_W-1:0] CHR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHR_DOT     = 8'h2e;
  localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_ONE     = 8'h31;
  localparam logic [CHAR_W-1:0] CHR_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CHR_UC_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_UC_F    = 8'h46;
  localparam logic [CHAR_W-1:0] CHR_UC_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CHR_LC_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CHR_LC_F    = 8'h66;
  localparam logic [CHAR_W-1:0] CHR_LC_X    = 8'h78;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_X      = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  localparam logic [7:0] BYTE_MAX  = 8'hff;
  localparam logic [PROD_W-1:0] VALUE_CAP = PROD_W'(64'h1_0000_0000);
  localparam logic [IDX_W-1:0]  PARTS_MAX = IDX_W'(4);

  typedef struct packed {
    logic [ADDR_W-1:0]  acc;
    logic [VALUE_W-1:0] value;
    logic [IDX_W-1:0]   idx;
    logic [LEN_W-1:0]   len;
    logic [1:0]         radix;
    logic [1:0]         phase;
    logic               err;
    logic               ign;
  } parse_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              error;
  } parse_result_t;

  localparam parse_state_t STATE_RESET = '{
    acc:   '0,
    value: '0,
    idx:   '0,
    len:   '0,
    radix: RADIX_DEC,
    phase: PH_START,
    err:   1'b0,
    ign:   1'b0
  };

endpackage

### rtl/ipv4p_ifs.sv
// ----------------------------------------------------------------------------
// ipv4p_ifs
// Valid/ready channels of the address parser: character in, address out.
// ----------------------------------------------------------------------------
interface ipv4p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface ipv4p_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        error;

  modport source (output valid, output address, output error, input ready);
  modport sink   (input valid, input address, input error, output ready);
endinterface

### rtl/ipv4p_step.sv
// ----------------------------------------------------------------------------
// ipv4p_step
// Next-state and result logic for one character of the address string.
// ----------------------------------------------------------------------------
module ipv4p_step
  import ipv4p_pkg::*;
#(
  parameter logic [LEN_W-1:0] MAX_CHARS = MAX_PART_CHARS
)
(
  input  parse_state_t        cur,
  input  logic [CHAR_W-1:0]   ch,
  output parse_state_t        nxt,
  output parse_result_t       res
);

  logic              is_dec;
  logic              is_lc;
  logic              is_uc;
  logic [3:0]        dig;
  logic              dig_ok;
  logic [PROD_W-1:0] v_ext;
  logic [PROD_W-1:0] prod;
  logic [LEN_W-1:0]  len_inc;
  logic              complete;
  logic              last_ovf;
  logic [1:0]        idx2;
  logic [ADDR_W-1:0] swapped;
  logic [ADDR_W-1:0] lane_mask;
  logic              fin_err;
  logic [ADDR_W-1:0] fin_acc;

  assign idx2     = cur.idx[1:0];
  assign complete = (cur.phase == PH_ZERO) || (cur.phase == PH_DIGITS);

  // digit decode
  assign is_dec = (ch >= CHR_ZERO) && (ch <= CHR_NINE);
  assign is_lc  = (ch >= CHR_LC_A) && (ch <= CHR_LC_F);
  assign is_uc  = (ch >= CHR_UC_A) && (ch <= CHR_UC_F);

  always_comb begin
    dig = 4'd0;
    if (is_dec) begin
      dig = 4'(ch - CHR_ZERO);
    end else if (is_lc) begin
      dig = 4'(ch - CHR_LC_A + 8'd10);
    end else if (is_uc) begin
      dig = 4'(ch - CHR_UC_A + 8'd10);
    end
  end

  always_comb begin
    case (cur.radix)
      RADIX_HEX: dig_ok = is_dec || is_lc || is_uc;
      RADIX_OCT: dig_ok = is_dec && (dig < 4'd8);
      default:   dig_ok = is_dec;
    endcase
  end

  // value * base + digit, saturating at 2^32
  assign v_ext = PROD_W'(cur.value);
  always_comb begin
    case (cur.radix)
      RADIX_HEX: prod = (v_ext << 4) + PROD_W'(dig);
      RADIX_OCT: prod = (v_ext << 3) + PROD_W'(dig);
      default:   prod = (v_ext << 3) + (v_ext << 1) + PROD_W'(dig);
    endcase
  end

  assign len_inc = (cur.len == LEN_SAT) ? cur.len : cur.len + LEN_W'(1);

  // last part must fit in the bytes left after the completed parts
  always_comb begin
    case (idx2)
      2'd0:    last_ovf = |cur.value[VALUE_W-1:32];
      2'd1:    last_ovf = |cur.value[VALUE_W-1:24];
      2'd2:    last_ovf = |cur.value[VALUE_W-1:16];
      default: last_ovf = |cur.value[VALUE_W-1:8];
    endcase
  end

  // byte k of the address takes byte 3-k of the value, for k at or above idx
  assign swapped   = {cur.value[7:0], cur.value[15:8], cur.value[23:16], cur.value[31:24]};
  assign lane_mask = {ADDR_W{1'b1}} << {idx2, 3'b000};

  always_comb begin
    fin_err = cur.err;
    fin_acc = cur.acc;
    if (!cur.err && !cur.ign) begin
      if (!complete || last_ovf) begin
        fin_err = 1'b1;
      end else begin
        fin_acc = cur.acc | (swapped & lane_mask);
      end
    end
  end

  assign res.error   = fin_err;
  assign res.address = fin_err ? {ADDR_W{1'b1}} : fin_acc;

  always_comb begin
    nxt = cur;
    if (ch == CHR_NUL) begin
      nxt = STATE_RESET;
    end else if (cur.err || cur.ign) begin
      nxt = cur;
    end else if (ch == CHR_DOT) begin
      if (!complete || (cur.value > VALUE_W'(BYTE_MAX))) begin
        nxt.err = 1'b1;
      end else begin
        nxt.acc   = cur.acc | (ADDR_W'(cur.value[7:0]) << {idx2, 3'b000});
        nxt.idx   = cur.idx + IDX_W'(1);
        nxt.ign   = (cur.idx + IDX_W'(1)) >= PARTS_MAX;
        nxt.value = '0;
        nxt.len   = '0;
        nxt.radix = RADIX_DEC;
        nxt.phase = PH_START;
      end
    end else begin
      nxt.len = len_inc;
      if (len_inc > MAX_CHARS) begin
        nxt.err = 1'b1;
      end else if (cur.phase == PH_START) begin
        if (ch == CHR_ZERO) begin
          nxt.radix = RADIX_OCT;
          nxt.phase = PH_ZERO;
          nxt.value = '0;
        end else if ((ch >= CHR_ONE) && (ch <= CHR_NINE)) begin
          nxt.radix = RADIX_DEC;
          nxt.phase = PH_DIGITS;
          nxt.value = VALUE_W'(dig);
        end else begin
          nxt.err = 1'b1;
        end
      end else if ((cur.phase == PH_ZERO) && ((ch == CHR_LC_X) || (ch == CHR_UC_X))) begin
        nxt.radix = RADIX_HEX;
        nxt.phase = PH_X;
      end else if (!dig_ok) begin
        nxt.err = 1'b1;
      end else begin
        nxt.value = (prod > VALUE_CAP) ? VALUE_W'(VALUE_CAP) : VALUE_W'(prod);
        nxt.phase = PH_DIGITS;
      end
    end
  end

endmodule

### rtl/ipv4_dotted_address_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_address_parser
// Parses a NUL-terminated dotted IPv4 address string, one character a beat.
// ----------------------------------------------------------------------------
// Input channel in_ch: one character per beat. Decimal, octal (leading 0)
// and hex (0x) parts separated by dots; a zero character ends the string.
// Output channel out_ch: one beat per string, sent for the terminating NUL,
// carrying the address (first part in the low byte) and an error flag.
// On error the address reads all ones.
// Throughput: one character per cycle while no NUL is held back, with the parse
// state register updated per character; the digit step is a shift-add by 8, 10 or 16.
// Result path: an accepted NUL goes into the input register, then into the
// result register once that register is free; the result beat is then valid.
// Stall: characters other than the NUL keep flowing while a result waits;
// a NUL sits in the input register until the result register frees up, and
// in_ch.ready drops behind it.
// Reset: clears the parse state and both valid flags; no result is pending.
// ----------------------------------------------------------------------------
module ipv4_dotted_address_parser
  import ipv4p_pkg::*;
#(
  parameter logic [LEN_W-1:0] MAX_CHARS = MAX_PART_CHARS
)
(
  input  logic        clk,
  input  logic        rst_n,
  ipv4p_in_if.sink    in_ch,
  ipv4p_out_if.source out_ch
);

  logic                s1_valid_r;
  logic [CHAR_W-1:0]   s1_char_r;
  parse_state_t        state_r;
  parse_state_t        state_nxt;
  parse_result_t       res_nxt;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_address_r;
  logic                out_error_r;
  logic                s1_nul;
  logic                s1_go;
  logic                in_ready;

  assign s1_nul   = (s1_char_r == CHR_NUL);
  assign s1_go    = s1_valid_r && (!s1_nul || !out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_go;

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.address = out_address_r;
  assign out_ch.error   = out_error_r;

  ipv4p_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .cur (state_r),
    .ch  (s1_char_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_char_r <= in_ch.character;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_nul) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_nul) begin
      out_address_r <= res_nxt.address;
      out_error_r   <= res_nxt.error;
    end
  end

endmodule

### bench/ipv4_address_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_address_checker
// Watches both channels of the address parser, predicts each result beat
// from the accepted characters and compares it field by field.
// ----------------------------------------------------------------------------
module ipv4_address_checker
  import ipv4p_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ipv4p_in_if         in_mon,
  ipv4p_out_if        out_mon,
  input  logic        end_check,
  output int          n_fail,
  output int          n_pending,
  output int          n_parsed
);

  localparam int PRINT_CAP = 100;

  // predicted parse state
  logic [ADDR_W-1:0]  addr_acc;
  logic [VALUE_W-1:0] part_val;
  logic [IDX_W-1:0]   part_idx;
  logic [LEN_W-1:0]   part_len;
  logic [1:0]         part_radix;
  logic [1:0]         part_phase;
  logic               str_err;
  logic               str_ign;

  parse_result_t expected_addresses[$];
  int            parsed_chars = 0;
  bit            leftover_seen = 1'b0;

  initial begin
    n_fail    = 0;
    n_pending = 0;
    n_parsed  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (n_fail < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    n_fail++;
  endtask

  task automatic clear_part();
    part_val   = '0;
    part_len   = '0;
    part_radix = RADIX_DEC;
    part_phase = PH_START;
  endtask

  task automatic clear_string();
    addr_acc = '0;
    part_idx = '0;
    str_err  = 1'b0;
    str_ign  = 1'b0;
    clear_part();
  endtask

  // One character through the predicted parser; emit is set on the NUL.
  task automatic parse_char(input logic [CHAR_W-1:0] c, output bit emit,
                            output parse_result_t res);
    logic [PROD_W-1:0] prod;
    int                radix_base;
    int                dig;
    int unsigned       slot;
    int unsigned       nbytes;
    emit = 1'b0;
    res  = '0;
    if (c == CHR_NUL) begin
      if (!str_err && !str_ign) begin
        // last part fills every byte left, most significant first
        slot   = part_idx[1:0];
        nbytes = PARTS_MAX - slot;
        if (!(part_phase == PH_ZERO || part_phase == PH_DIGITS)) begin
          str_err = 1'b1;
        end else if ((part_val >> (8 * nbytes)) != '0) begin
          str_err = 1'b1;
        end else begin
          for (int q = 0; q < nbytes; q++) begin
            addr_acc |= ADDR_W'(8'(part_val >> (8 * (nbytes - 1 - q))))
                        << (8 * (slot + q));
          end
        end
      end
      emit        = 1'b1;
      res.address = str_err ? '1 : addr_acc;
      res.error   = str_err;
      clear_string();
      return;
    end
    if (str_err || str_ign) return;

    if (c == CHR_DOT) begin
      if (!(part_phase == PH_ZERO || part_phase == PH_DIGITS) ||
          part_val > VALUE_W'(BYTE_MAX)) begin
        str_err = 1'b1;
        return;
      end
      addr_acc |= ADDR_W'(part_val[7:0]) << (8 * part_idx[1:0]);
      part_idx = part_idx + 1'b1;
      if (part_idx >= PARTS_MAX) str_ign = 1'b1;
      clear_part();
      return;
    end

    if (part_len != LEN_SAT) part_len = part_len + 1'b1;
    if (part_len > MAX_PART_CHARS) begin
      str_err = 1'b1;
      return;
    end

    if (part_phase == PH_START) begin
      if (c == CHR_ZERO) begin
        part_radix = RADIX_OCT;
        part_phase = PH_ZERO;
        part_val   = '0;
      end else if (c >= CHR_ONE && c <= CHR_NINE) begin
        part_radix = RADIX_DEC;
        part_phase = PH_DIGITS;
        part_val   = VALUE_W'(c - CHR_ZERO);
      end else begin
        str_err = 1'b1;
      end
      return;
    end
    if (part_phase == PH_ZERO && (c == CHR_LC_X || c == CHR_UC_X)) begin
      part_radix = RADIX_HEX;
      part_phase = PH_X;
      return;
    end

    radix_base = (part_radix == RADIX_HEX) ? 16 : ((part_radix == RADIX_OCT) ? 8 : 10);
    if (c >= CHR_ZERO && c <= CHR_NINE) begin
      dig = int'(c - CHR_ZERO);
    end else if (c >= CHR_LC_A && c <= CHR_LC_F) begin
      dig = int'(c - CHR_LC_A) + 10;
    end else if (c >= CHR_UC_A && c <= CHR_UC_F) begin
      dig = int'(c - CHR_UC_A) + 10;
    end else begin
      dig = -1;
    end
    if (dig < 0 || dig >= radix_base) begin
      str_err = 1'b1;
      return;
    end
    prod = PROD_W'(part_val) * PROD_W'(radix_base) + PROD_W'(dig);
    if (prod > VALUE_CAP) prod = VALUE_CAP;
    part_val   = VALUE_W'(prod);
    part_phase = PH_DIGITS;
  endtask

  always @(posedge clk) begin
    parse_result_t want;
    bit            emit;
    if (!rst_n) begin
      clear_string();
      expected_addresses.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_addresses.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: address %08h error %0b",
                                    out_mon.address, out_mon.error));
        end else begin
          want = expected_addresses.pop_front();
          if (out_mon.address !== want.address) begin
            report_mismatch($sformatf("address %08h, expected %08h",
                                      out_mon.address, want.address));
          end
          if (out_mon.error !== want.error) begin
            report_mismatch($sformatf("error %0b, expected %0b",
                                      out_mon.error, want.error));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        parsed_chars++;
        parse_char(in_mon.character, emit, want);
        if (emit) expected_addresses.push_back(want);
      end
      if (end_check && !leftover_seen && expected_addresses.size() != 0) begin
        leftover_seen = 1'b1;
        report_mismatch($sformatf("%0d expected results never arrived",
                                  expected_addresses.size()));
      end
    end
    n_pending <= expected_addresses.size();
    n_parsed  <= parsed_chars;
  end

endmodule

### bench/tb_ipv4_dotted_address_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_dotted_address_parser
// Feeds address strings to the parser: a directed set of corner strings,
// then random dotted addresses in every base, some of them damaged, under
// three sender/receiver idle mixes and a long receiver hold-off. Results
// are checked by ipv4_address_checker.
// ----------------------------------------------------------------------------
module tb_ipv4_dotted_address_parser;
  import ipv4p_pkg::*;

  typedef logic [CHAR_W-1:0] text_t[$];

  localparam int RESET_CYCLES   = 7;
  localparam int CHARS_PER_PASS = 590;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int N_DIRECTED     = 23;

  logic clk = 1'b0;
  logic rst_n;
  logic end_check;
  int   n_fail;
  int   n_pending;
  int   n_parsed;
  int   cycle_count = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  bit   hold_req = 1'b0;

  string directed_text [N_DIRECTED] = '{
    "",
    "255.255.255.255",
    "0.0.0.0",
    "0xFFFFFFFF",
    "4294967295",
    "4294967296",
    "01.0x7f.0377.0Xa",
    "1.16777215",
    "1.2.65536",
    "256.1",
    "1..2",
    "0x.1",
    "08",
    " 1",
    "1.2.3.4.junk\377",
    "00000000001",
    "0000000001",
    "0xg",
    "-1",
    "1.2.3.",
    "1a",
    "9999999999",
    "1.2.3.256"
  };

  ipv4p_in_if  in_ch ();
  ipv4p_out_if out_ch ();

  ipv4_dotted_address_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ipv4_address_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .end_check (end_check),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_parsed  (n_parsed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Random dotted address: one to five parts in mixed bases, mostly in range.
  function automatic text_t random_address();
    text_t         t;
    int unsigned   nparts;
    int unsigned   nbytes;
    int unsigned   w;
    int unsigned   pad;
    logic [63:0]   v;
    logic [7:0]    c;
    string         s;
    nparts = $urandom_range(5, 1);
    for (int p = 0; p < nparts; p++) begin
      nbytes = (p == nparts - 1 && p < PARTS_MAX) ? PARTS_MAX - p : 1;
      w = 8 * nbytes + (($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0);
      v = {$urandom, $urandom} & ((64'd1 << w) - 1);
      if ($urandom_range(3) == 0) v = v >> $urandom_range(w);
      pad = ($urandom_range(7) == 0) ? $urandom_range(6, 1) : 0;
      case ($urandom_range(2))
        0: s = $sformatf("%0d", v);
        1: begin
          s = "0";
          repeat (pad) s = {s, "0"};
          s = {s, $sformatf("%0o", v)};
        end
        default: begin
          s = $urandom_range(1) ? "0x" : "0X";
          repeat (pad) s = {s, "0"};
          s = {s, $sformatf("%0h", v)};
        end
      endcase
      for (int k = 0; k < s.len(); k++) begin
        c = s[k];
        if (c >= CHR_LC_A && c <= CHR_LC_F && $urandom_range(1)) c = c - (CHR_LC_A - CHR_UC_A);
        t.push_back(c);
      end
      if (p < nparts - 1) t.push_back(CHR_DOT);
    end
    // about a third get damaged: stray byte, dropped character or extra dot
    if ($urandom_range(9) < 3) begin
      case ($urandom_range(3))
        0: t[$urandom_range(t.size() - 1)] = 8'($urandom_range(255, 1));
        1: t.insert($urandom_range(t.size()), 8'($urandom_range(255, 1)));
        2: t.delete($urandom_range(t.size() - 1));
        default: t.insert($urandom_range(t.size()), CHR_DOT);
      endcase
    end
    return t;
  endfunction

  // Sends the string and its closing NUL, one beat per character.
  task automatic send_text(input text_t t);
    logic [CHAR_W-1:0] c;
    for (int i = 0; i <= t.size(); i++) begin
      c = (i == t.size()) ? CHR_NUL : t[i];
      while ($urandom_range(99) < tx_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid     <= 1'b1;
      in_ch.character <= c;
      do @(posedge clk); while (!in_ch.ready);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    text_t t;
    int    target;
    rst_n           = 1'b0;
    end_check       = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.character = CHR_NUL;
    tx_idle_pct     = 21;
    rx_idle_pct     = 75;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_text[i]) begin
      t.delete();
      for (int k = 0; k < directed_text[i].len(); k++) t.push_back(directed_text[i][k]);
      send_text(t);
    end

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          tx_idle_pct = 21;
          rx_idle_pct = 75;
        end
        1: begin
          tx_idle_pct = 75;
          rx_idle_pct = 21;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      target = n_parsed + CHARS_PER_PASS;
      while (n_parsed < target) send_text(random_address());
      // sender pauses until every result is back
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (n_pending != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
